/* rtl/ipvr_pkg.sv */
// ----------------------------------------------------------------------------
// ipvr_pkg
// Shared types and constants of the insertion/promotion-vector recency
// replacement block.
// ----------------------------------------------------------------------------
package ipvr_pkg;

    localparam int IPVR_NUM_SETS = 64;
    localparam int NUM_WAYS      = 16;
    localparam int POS_W         = 4;
    localparam int WAY_W         = 4;
    localparam int KIND_W        = 2;
    localparam int SET_IDX_W     = 6;
    localparam int SET_IDX_NUM   = 64;
    localparam int PV_W          = 64;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [PV_W-1:0]  PV_RESET     = 64'h9EDC_8E08_1414_8200;
    localparam logic [POS_W-1:0] INSERT_RESET = 4'd5;
    localparam logic [POS_W-1:0] BOTTOM_POS   = 4'd15;

    // Address bit that picks the register (registers sit 8 bytes apart).
    localparam int CFG_SEL_BIT = 3;

    typedef enum logic [0:0] {
        REG_PROMOTION_VECTOR = 1'b0,
        REG_INSERT_POSITION  = 1'b1
    } ipvr_reg_t;

    typedef enum logic [KIND_W-1:0] {
        OP_HIT   = 2'd0,
        OP_FILL  = 2'd1,
        OP_INVAL = 2'd2,
        OP_QUERY = 2'd3
    } ipvr_op_t;

    // One recency stack: nibble i is the stack position of way i.
    typedef logic [NUM_WAYS-1:0][POS_W-1:0] ipvr_row_t;

    localparam ipvr_row_t ROW_RESET = 64'hFEDC_BA98_7654_3210;

    typedef struct packed {
        ipvr_op_t               op;
        logic [SET_IDX_W-1:0]   set;
        logic [WAY_W-1:0]       way;
    } ipvr_item_t;

    typedef struct packed {
        logic       valid;
        ipvr_item_t item;
    } ipvr_qhead_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } ipvr_back_ctl_t;

endpackage

/* rtl/ipvr_cfg.sv */
// ----------------------------------------------------------------------------
// ipvr_cfg
// APB register file: promotion vector and insertion position.
// ----------------------------------------------------------------------------
module ipvr_cfg
    import ipvr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [PV_W-1:0]       promotion_vector,
    output logic [POS_W-1:0]      insert_position
);

    logic [PV_W-1:0]  pv_reg;
    logic [POS_W-1:0] ins_reg;
    logic             wr_en;
    ipvr_reg_t        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = ipvr_reg_t'(paddr[CFG_SEL_BIT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg  <= PV_RESET;
            ins_reg <= INSERT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_PROMOTION_VECTOR: pv_reg  <= pwdata[PV_W-1:0];
                REG_INSERT_POSITION:  ins_reg <= pwdata[POS_W-1:0];
                default:              pv_reg  <= pv_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_PROMOTION_VECTOR: prdata = pv_reg;
            REG_INSERT_POSITION:  prdata = {{(CFG_DATA_W-POS_W){1'b0}}, ins_reg};
            default:              prdata = '0;
        endcase
    end

    assign promotion_vector = pv_reg;
    assign insert_position  = ins_reg;

endmodule

/* rtl/ipvr_front.sv */
// ----------------------------------------------------------------------------
// ipvr_front
// Accept input beats, decode the operation, fold the set index and hold the
// items in a short queue for the update engine.
// ----------------------------------------------------------------------------
module ipvr_front
    import ipvr_pkg::*;
#(
    parameter int NUM_SETS = IPVR_NUM_SETS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [KIND_W-1:0]    kind,
    input  logic [SET_IDX_W-1:0] set_index,
    input  logic [WAY_W-1:0]     way,
    input  ipvr_back_ctl_t       back_ctl,
    output ipvr_qhead_t          qhead
);

    logic [SET_IDX_W-1:0] set_map [SET_IDX_NUM];
    ipvr_item_t           q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    ipvr_item_t           new_item;
    logic                 push;
    logic                 pop;

    // Set index folded onto the sets that exist.
    for (genvar i = 0; i < SET_IDX_NUM; i++)
    begin : g_set_map
        assign set_map[i] = SET_IDX_W'(i % NUM_SETS);
    end

    // Every kind encoding is a valid operation.
    always_comb
    begin
        new_item.op  = ipvr_op_t'(kind);
        new_item.set = set_map[set_index];
        new_item.way = way;
    end

    assign item_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH)) && !back_ctl.clearing;
    assign push       = item_valid & item_ready;
    assign pop        = back_ctl.pop;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign qhead.valid = (cnt_reg != '0);
    assign qhead.item  = q_mem_reg[rd_ptr_reg];

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("pop from empty queue");

    a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
        back_ctl.clearing |-> !push)
        else $error("item taken during clearing pass");

endmodule

/* rtl/ipvr_back.sv */
// ----------------------------------------------------------------------------
// ipvr_back
// Update engine: clear the stack memory after reset, read the addressed set,
// move the way, write the set back and register the result.
// ----------------------------------------------------------------------------
module ipvr_back
    import ipvr_pkg::*;
#(
    parameter int NUM_SETS = IPVR_NUM_SETS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ipvr_qhead_t       qhead,
    output ipvr_back_ctl_t    back_ctl,
    input  logic [PV_W-1:0]   promotion_vector,
    input  logic [POS_W-1:0]  insert_position,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [WAY_W-1:0]  victim_way,
    output logic [POS_W-1:0]  way_position
);

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC
    } state_t;

    state_t           state_reg;
    logic [SET_W-1:0] clr_cnt_reg;
    ipvr_item_t       cur_reg;
    ipvr_row_t        rd_row_reg;
    logic             out_valid_reg;
    logic [WAY_W-1:0] victim_reg;
    logic [POS_W-1:0] wpos_reg;

    ipvr_row_t        mem [NUM_SETS];

    logic             pop;
    logic             wr_en;
    logic [SET_W-1:0] wr_addr;
    ipvr_row_t        wr_row;
    logic [SET_W-1:0] rd_addr;
    logic [SET_W-1:0] cur_addr;

    logic [POS_W-1:0] old_pos;
    logic [POS_W-1:0] tgt_pos;
    ipvr_row_t        new_row;
    logic [WAY_W-1:0] victim_next;
    logic [POS_W-1:0] wpos_next;

    // Take the next item once the result register is free or being drained.
    assign pop = (state_reg == S_IDLE) && qhead.valid
                 && (!out_valid_reg || result_ready);

    assign back_ctl.pop      = pop;
    assign back_ctl.clearing = (state_reg == S_CLEAR);

    assign rd_addr  = SET_W'(qhead.item.set);
    assign cur_addr = SET_W'(cur_reg.set);

    // Move one way in the stack and shift the ways in between.
    always_comb
    begin
        old_pos = rd_row_reg[cur_reg.way];
        case (cur_reg.op)
            OP_HIT:   tgt_pos = promotion_vector[{old_pos, 2'b00} +: POS_W];
            OP_FILL:  tgt_pos = insert_position;
            OP_INVAL: tgt_pos = BOTTOM_POS;
            default:  tgt_pos = old_pos;
        endcase

        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (WAY_W'(i) == cur_reg.way)
            begin
                new_row[i] = tgt_pos;
            end
            else if ((tgt_pos < old_pos) && (rd_row_reg[i] >= tgt_pos)
                     && (rd_row_reg[i] < old_pos))
            begin
                new_row[i] = rd_row_reg[i] + 1'b1;
            end
            else if ((tgt_pos > old_pos) && (rd_row_reg[i] > old_pos)
                     && (rd_row_reg[i] <= tgt_pos))
            begin
                new_row[i] = rd_row_reg[i] - 1'b1;
            end
            else
            begin
                new_row[i] = rd_row_reg[i];
            end
        end

        // Lowest way at the bottom of the stack.
        victim_next = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (new_row[i] == BOTTOM_POS)
            begin
                victim_next = WAY_W'(i);
            end
        end

        wpos_next = (cur_reg.op == OP_QUERY) ? '0 : tgt_pos;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_row  = new_row;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_row  = ROW_RESET;
            end
            S_CALC:
            begin
                wr_en = (cur_reg.op != OP_QUERY);
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (pop)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= qhead.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            victim_reg    <= '0;
            wpos_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    out_valid_reg <= 1'b1;
                    victim_reg    <= victim_next;
                    wpos_reg      <= wpos_next;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign victim_way   = victim_reg;
    assign way_position = wpos_reg;

    a_calc_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CALC |-> !out_valid_reg)
        else $error("result register busy when update completes");

    a_calc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CALC |=> out_valid_reg)
        else $error("update finished without a result");

    a_pop_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_CALC)
        else $error("popped item not processed");

endmodule

/* rtl/ipv_recency_replacement.sv */
// ----------------------------------------------------------------------------
// ipv_recency_replacement
// Insertion/promotion-vector recency replacement for a 16-way cache.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready): kind, set_index, way. Kind selects
//   hit, fill, invalidate or victim query. Each beat yields exactly one
//   result beat on the result channel (result_valid/result_ready) carrying
//   victim_way (way now at stack position 15) and way_position (new
//   position of the addressed way, 0 for a query).
//   Engine: an item leaves the queue once the result register is free or
//   draining; its set is read from the set memory in S_IDLE, then updated,
//   written back and its result registered in S_CALC, before the next item.
//   A 2-entry queue sits between the item side and the update engine, so
//   items keep being taken while a result waits for result_ready; once the
//   queue is full, item_ready drops until the result side drains.
//   Reset: the registers take their defaults and a clearing pass writes the
//   initial stack into every set, one set per cycle. item_ready stays low
//   until it ends; APB writes are taken throughout.
//   Configuration (APB, pready always high): promotion_vector at 0x0,
//   insert_position at 0x8. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module ipv_recency_replacement
    import ipvr_pkg::*;
#(
    parameter int NUM_SETS = IPVR_NUM_SETS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    // Item channel
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic [KIND_W-1:0]     kind,
    input  logic [SET_IDX_W-1:0]  set_index,
    input  logic [WAY_W-1:0]      way,

    // Result channel
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [WAY_W-1:0]      victim_way,
    output logic [POS_W-1:0]      way_position
);

    logic [PV_W-1:0]  promotion_vector;
    logic [POS_W-1:0] insert_position;
    ipvr_qhead_t      qhead;
    ipvr_back_ctl_t   back_ctl;

    // Configuration registers
    ipvr_cfg u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .promotion_vector (promotion_vector),
        .insert_position  (insert_position)
    );

    // Front: take beats, decode, fold the set index, queue
    ipvr_front #(
        .NUM_SETS (NUM_SETS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .kind       (kind),
        .set_index  (set_index),
        .way        (way),
        .back_ctl   (back_ctl),
        .qhead      (qhead)
    );

    // Back: read-modify-write of the recency stack, hold the result
    ipvr_back #(
        .NUM_SETS (NUM_SETS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .qhead            (qhead),
        .back_ctl         (back_ctl),
        .promotion_vector (promotion_vector),
        .insert_position  (insert_position),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .victim_way       (victim_way),
        .way_position     (way_position)
    );

endmodule
